// ===== src/i2c_master_transfer_sequencer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_UNIT_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CMTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/i2cmts_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Phase type, command, status and operation codes, and field widths.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

    localparam int unsigned RX_FIFO_DEPTH_DEFAULT = 256;

    localparam int unsigned ADDR_W   = 7;
    localparam int unsigned LENGTH_W = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [ADDR_W-1:0] ADDR_MASK = 7'h7F;
    localparam logic              RW_READ   = 1'b1;

    // Register index as seen in paddr[2].
    localparam logic REG_TARGET_ADDRESS = 1'b0;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ADDR = 3'd1,
        PH_TX   = 3'd2,
        PH_RX   = 3'd3,
        PH_RXRS = 3'd4,
        PH_STOP = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_DONE   = 2'd1,
        OP_RXBYTE = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_SEND_START = 2'd0,
        CMD_TX         = 2'd1,
        CMD_RX         = 2'd2,
        CMD_SEND_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOTSUP = 2'd1,
        ST_NODEV  = 2'd2,
        ST_IOERR  = 2'd3
    } status_t;

endpackage

// ===== src/i2c_master_transfer_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// An accepted item's result is registered. Throughput: one item per cycle while
// the output register is empty or being drained; the phase update is a single
// combinational pass between the input ports and the registered result.
// Reset (aresetn low at a clock edge, synchronous): phase idle, counters zero,
// target address zero, output register empty.
// ----------------------------------------------------------------------------
`include "i2c_master_transfer_sequencer_unit_macros.svh"

module i2c_master_transfer_sequencer_unit #(
    parameter int unsigned RX_FIFO_DEPTH = i2cmts_pkg::RX_FIFO_DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [i2cmts_pkg::PADDR_W-1:0]    paddr,
    input  logic [i2cmts_pkg::PDATA_W-1:0]    pwdata,
    output logic [i2cmts_pkg::PDATA_W-1:0]    prdata,
    output logic                              pready,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_op,
    input  logic                              s_read_dir,
    input  logic [i2cmts_pkg::LENGTH_W-1:0]   s_length,
    input  logic                              s_ends_sequence,
    input  logic                              s_ten_bit_mode,
    input  logic                              s_nak_flag,
    input  logic                              s_proto_err_flag,
    input  logic [i2cmts_pkg::BYTE_W-1:0]     s_data_byte,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_cmd_valid,
    output logic [1:0]                        m_cmd_code,
    output logic [i2cmts_pkg::BYTE_W-1:0]     m_cmd_data,
    output logic                              m_store_valid,
    output logic [i2cmts_pkg::LENGTH_W-1:0]   m_store_offset,
    output logic [i2cmts_pkg::BYTE_W-1:0]     m_store_value,
    output logic [i2cmts_pkg::LENGTH_W-1:0]   m_byte_count,
    output logic                              m_done_res,
    output logic [1:0]                        m_status
);

    localparam int unsigned BURST_W = $clog2(RX_FIFO_DEPTH + 1);
    localparam int unsigned LEN_W   = i2cmts_pkg::LENGTH_W;
    localparam int unsigned B_W     = i2cmts_pkg::BYTE_W;
    localparam logic [LEN_W-1:0]   DEPTH_LEN   = LEN_W'(RX_FIFO_DEPTH);
    localparam logic [BURST_W-1:0] DEPTH_BURST = BURST_W'(RX_FIFO_DEPTH);

    // Configuration
    logic [i2cmts_pkg::ADDR_W-1:0] target_address_reg;
    logic                          cfg_write;

    // Sequencer state
    i2cmts_pkg::phase_t  phase_reg, phase_next;
    logic                dir_read_reg, dir_read_next;
    logic                end_flag_reg, end_flag_next;
    logic [LEN_W-1:0]    total_length_reg, total_length_next;
    logic [LEN_W-1:0]    done_count_reg, done_count_next;
    logic [BURST_W-1:0]  burst_left_reg, burst_left_next;

    // Result register
    logic                m_valid_reg;
    logic                cmd_valid_reg, cmd_valid_next;
    logic [1:0]          cmd_code_reg, cmd_code_next;
    logic [B_W-1:0]      cmd_data_reg, cmd_data_next;
    logic                store_valid_reg, store_valid_next;
    logic [LEN_W-1:0]    store_offset_reg, store_offset_next;
    logic [B_W-1:0]      store_value_reg, store_value_next;
    logic [LEN_W-1:0]    byte_count_reg, byte_count_next;
    logic                done_res_reg, done_res_next;
    logic [1:0]          status_reg, status_next;

    // Intermediate decisions of the combinational pass
    logic                accept;
    logic                do_finish;
    logic                do_burst;
    logic                do_complete;
    i2cmts_pkg::status_t cmpl_status;
    logic [LEN_W-1:0]    count_inc;
    logic [LEN_W-1:0]    remaining;
    logic [LEN_W-1:0]    chunk;
    logic [B_W-1:0]      addr_rw;
    logic [B_W-1:0]      addr_rd;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == i2cmts_pkg::REG_TARGET_ADDRESS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_address_reg <= '0;
        end else if (cfg_write) begin
            target_address_reg <= pwdata[i2cmts_pkg::ADDR_W-1:0] & i2cmts_pkg::ADDR_MASK;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == i2cmts_pkg::REG_TARGET_ADDRESS) begin
            prdata = {{(i2cmts_pkg::PDATA_W - i2cmts_pkg::ADDR_W){1'b0}}, target_address_reg};
        end
    end

    // ------------------------------------------------------------------
    // Handshake: a new transfer is taken whenever the result register is
    // empty or is being drained in the same cycle.
    // ------------------------------------------------------------------
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign addr_rw   = {target_address_reg, s_read_dir};
    assign addr_rd   = {target_address_reg, i2cmts_pkg::RW_READ};
    assign count_inc = done_count_reg + LEN_W'(1);
    assign remaining = (total_length_reg > done_count_reg) ?
                       (total_length_reg - done_count_reg) : '0;
    assign chunk     = (remaining > DEPTH_LEN) ? DEPTH_LEN : remaining;

    // ------------------------------------------------------------------
    // Phase update and result formation
    // ------------------------------------------------------------------
    always_comb begin
        phase_next        = phase_reg;
        dir_read_next     = dir_read_reg;
        end_flag_next     = end_flag_reg;
        total_length_next = total_length_reg;
        done_count_next   = done_count_reg;
        burst_left_next   = burst_left_reg;

        cmd_valid_next    = 1'b0;
        cmd_code_next     = i2cmts_pkg::CMD_SEND_START;
        cmd_data_next     = '0;
        store_valid_next  = 1'b0;
        store_offset_next = '0;
        store_value_next  = '0;
        done_res_next     = 1'b0;
        status_next       = i2cmts_pkg::ST_OK;
        byte_count_next   = '0;

        do_finish   = 1'b0;
        do_burst    = 1'b0;
        do_complete = 1'b0;
        cmpl_status = i2cmts_pkg::ST_OK;

        unique case (i2cmts_pkg::op_t'(s_op))
            i2cmts_pkg::OP_START: begin
                if (phase_reg == i2cmts_pkg::PH_IDLE) begin
                    if (s_ten_bit_mode) begin
                        done_count_next = '0;
                        do_complete     = 1'b1;
                        cmpl_status     = i2cmts_pkg::ST_NOTSUP;
                    end else begin
                        dir_read_next     = s_read_dir;
                        total_length_next = s_length;
                        end_flag_next     = s_ends_sequence;
                        done_count_next   = '0;
                        burst_left_next   = '0;
                        phase_next        = i2cmts_pkg::PH_ADDR;
                        cmd_valid_next    = 1'b1;
                        cmd_code_next     = i2cmts_pkg::CMD_SEND_START;
                        cmd_data_next     = addr_rw;
                    end
                end
            end
            i2cmts_pkg::OP_DONE: begin
                if (phase_reg != i2cmts_pkg::PH_IDLE) begin
                    if (s_proto_err_flag) begin
                        do_complete = 1'b1;
                        cmpl_status = i2cmts_pkg::ST_IOERR;
                    end else begin
                        unique case (phase_reg)
                            i2cmts_pkg::PH_ADDR: begin
                                if (s_nak_flag) begin
                                    do_complete = 1'b1;
                                    cmpl_status = i2cmts_pkg::ST_NODEV;
                                end else if (total_length_reg == '0) begin
                                    do_finish = 1'b1;
                                end else if (!dir_read_reg) begin
                                    phase_next     = i2cmts_pkg::PH_TX;
                                    cmd_valid_next = 1'b1;
                                    cmd_code_next  = i2cmts_pkg::CMD_TX;
                                    cmd_data_next  = s_data_byte;
                                end else begin
                                    do_burst = 1'b1;
                                end
                            end
                            i2cmts_pkg::PH_TX: begin
                                // A NAK on a data byte ends the write early but cleanly.
                                if (s_nak_flag) begin
                                    do_finish = 1'b1;
                                end else begin
                                    done_count_next = count_inc;
                                    if (count_inc < total_length_reg) begin
                                        cmd_valid_next = 1'b1;
                                        cmd_code_next  = i2cmts_pkg::CMD_TX;
                                        cmd_data_next  = s_data_byte;
                                    end else begin
                                        do_finish = 1'b1;
                                    end
                                end
                            end
                            i2cmts_pkg::PH_RX: begin
                                if (s_nak_flag) begin
                                    do_complete = 1'b1;
                                    cmpl_status = i2cmts_pkg::ST_NODEV;
                                end else begin
                                    burst_left_next = '0;
                                    if (done_count_reg < total_length_reg) begin
                                        phase_next     = i2cmts_pkg::PH_RXRS;
                                        cmd_valid_next = 1'b1;
                                        cmd_code_next  = i2cmts_pkg::CMD_SEND_START;
                                        cmd_data_next  = addr_rd;
                                    end else begin
                                        do_finish = 1'b1;
                                    end
                                end
                            end
                            i2cmts_pkg::PH_RXRS: begin
                                if (s_nak_flag) begin
                                    do_complete = 1'b1;
                                    cmpl_status = i2cmts_pkg::ST_NODEV;
                                end else begin
                                    do_burst = 1'b1;
                                end
                            end
                            i2cmts_pkg::PH_STOP: begin
                                do_complete = 1'b1;
                                cmpl_status = i2cmts_pkg::ST_OK;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            i2cmts_pkg::OP_RXBYTE: begin
                if (phase_reg == i2cmts_pkg::PH_RX && burst_left_reg != '0 &&
                    done_count_reg < total_length_reg) begin
                    store_valid_next  = 1'b1;
                    store_offset_next = done_count_reg;
                    store_value_next  = s_data_byte;
                    done_count_next   = count_inc;
                    burst_left_next   = burst_left_reg - BURST_W'(1);
                end
            end
            i2cmts_pkg::OP_UNUSED: begin
            end
        endcase

        // A new read burst asks for the rest, capped at the FIFO depth.
        if (do_burst) begin
            if (chunk == '0) begin
                do_finish = 1'b1;
            end else begin
                burst_left_next = BURST_W'(chunk);
                phase_next      = i2cmts_pkg::PH_RX;
                cmd_valid_next  = 1'b1;
                cmd_code_next   = i2cmts_pkg::CMD_RX;
                cmd_data_next   = B_W'(chunk - LEN_W'(1));
            end
        end

        if (do_finish) begin
            if (end_flag_reg) begin
                phase_next     = i2cmts_pkg::PH_STOP;
                cmd_valid_next = 1'b1;
                cmd_code_next  = i2cmts_pkg::CMD_SEND_STOP;
                cmd_data_next  = '0;
            end else begin
                do_complete = 1'b1;
                cmpl_status = i2cmts_pkg::ST_OK;
            end
        end

        if (do_complete) begin
            done_res_next   = 1'b1;
            status_next     = cmpl_status;
            byte_count_next = (cmpl_status == i2cmts_pkg::ST_OK) ? done_count_next : '0;
            phase_next      = i2cmts_pkg::PH_IDLE;
            done_count_next = '0;
            burst_left_next = '0;
        end else begin
            byte_count_next = done_count_next;
        end
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= i2cmts_pkg::PH_IDLE;
            dir_read_reg     <= 1'b0;
            end_flag_reg     <= 1'b0;
            total_length_reg <= '0;
            done_count_reg   <= '0;
            burst_left_reg   <= '0;
        end else if (accept) begin
            phase_reg        <= phase_next;
            dir_read_reg     <= dir_read_next;
            end_flag_reg     <= end_flag_next;
            total_length_reg <= total_length_next;
            done_count_reg   <= done_count_next;
            burst_left_reg   <= burst_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_valid_reg    <= cmd_valid_next;
            cmd_code_reg     <= cmd_code_next;
            cmd_data_reg     <= cmd_data_next;
            store_valid_reg  <= store_valid_next;
            store_offset_reg <= store_offset_next;
            store_value_reg  <= store_value_next;
            byte_count_reg   <= byte_count_next;
            done_res_reg     <= done_res_next;
            status_reg       <= status_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cmd_valid    = cmd_valid_reg;
    assign m_cmd_code     = cmd_code_reg;
    assign m_cmd_data     = cmd_data_reg;
    assign m_store_valid  = store_valid_reg;
    assign m_store_offset = store_offset_reg;
    assign m_store_value  = store_value_reg;
    assign m_byte_count   = byte_count_reg;
    assign m_done_res     = done_res_reg;
    assign m_status       = status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `I2CMTS_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn,
        accept, m_valid_reg, "accepted transfer produced no result")
    `I2CMTS_ASSERT_SAME(a_idle_counters_clear, aclk, aresetn,
        phase_reg == i2cmts_pkg::PH_IDLE, done_count_reg == '0 && burst_left_reg == '0,
        "counters not clear while idle")
    `I2CMTS_ASSERT_SAME(a_burst_within_depth, aclk, aresetn,
        1'b1, burst_left_reg <= DEPTH_BURST, "burst count exceeds FIFO depth")
    `I2CMTS_ASSERT_SAME(a_error_count_zero, aclk, aresetn,
        m_valid_reg && done_res_reg && status_reg != i2cmts_pkg::ST_OK,
        byte_count_reg == '0, "failed transfer reports a nonzero byte count")
    `I2CMTS_ASSERT_SAME(a_store_exclusive, aclk, aresetn,
        m_valid_reg && store_valid_reg, !cmd_valid_reg && !done_res_reg,
        "store result combined with a command or completion")

endmodule
